[rtl/frwt_pkg.sv]
// Package: request/status codes, record, command and result structs and shared constants for the wear table.
package frwt_pkg;

	typedef enum logic [2:0] {
		REQ_ERASE  = 3'd0,
		REQ_ALLOC  = 3'd1,
		REQ_FREE   = 3'd2,
		REQ_WORN   = 3'd3,
		REQ_QUERY  = 3'd4,
		REQ_BEST   = 3'd5,
		REQ_STATS  = 3'd6,
		REQ_UNUSED = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OUTSIDE   = 3'd1,
		ST_BAD       = 3'd2,
		ST_NONE_FREE = 3'd3,
		ST_ALL_WORN  = 3'd4
	} status_t;

	localparam logic [1:0] CFG_BASE      = 2'd0;
	localparam logic [1:0] CFG_SIZE      = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;

	localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
	localparam logic [31:0] SIZE_RESET     = 32'd65536;
	localparam logic [31:0] THRESHOLD_RESET = 32'd100000;

	// One circulating region record
	typedef struct packed {
		logic [31:0] cnt;
		logic        busy;
		logic        worn;
	} region_t;

	// Commands broadcast from the sequencer to every cell
	typedef struct packed {
		logic shift;      // rotate the ring by one position
		logic inc;        // increment the head record (saturating)
		logic set_worn;   // set worn on the head record
		logic worn_thr;   // set worn when incremented count reaches threshold
		logic set_busy;   // set busy on the head record
		logic clr_busy;   // clear busy on the head record
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_addr;
		logic [31:0] erase_count;
		logic        critical;
		logic [31:0] min_count;
		logic [31:0] max_count;
		logic [31:0] avg_count;
	} result_t;

endpackage

[rtl/frwt_if.sv]
// Interfaces: request, result and configuration-write channels.
interface frwt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] addr;
	modport source (output valid, req_type, addr, input ready);
	modport sink (input valid, req_type, addr, output ready);
endinterface

interface frwt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_addr;
	logic [31:0] erase_count;
	logic        critical;
	logic [31:0] min_count;
	logic [31:0] max_count;
	logic [31:0] avg_count;
	modport source (output valid, status, out_addr, erase_count, critical,
		min_count, max_count, avg_count, input ready);
	modport sink (input valid, status, out_addr, erase_count, critical,
		min_count, max_count, avg_count, output ready);
endinterface

interface frwt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/frwt_cell.sv]
// One ring cell: holds one region record and passes it to its neighbor on shift.
module frwt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  frwt_pkg::cell_cmd_t cmd,
	input  logic               is_head,
	input  logic [31:0]        threshold,
	input  frwt_pkg::region_t  prev_rec,
	output frwt_pkg::region_t  rec
);
	import frwt_pkg::*;

	region_t rec_q;
	region_t upd;
	logic [31:0] inc_cnt;

	assign rec = rec_q;

	// Head update: the sequencer only modifies the record sitting in the head cell
	always_comb begin
		upd = rec_q;
		inc_cnt = (rec_q.cnt == COUNT_MAX) ? rec_q.cnt : rec_q.cnt + 32'd1;
		if (cmd.inc) begin
			upd.cnt = inc_cnt;
			if (cmd.worn_thr && inc_cnt >= threshold) begin
				upd.worn = 1'b1;
			end
		end
		if (cmd.set_worn) begin
			upd.worn = 1'b1;
		end
		if (cmd.set_busy) begin
			upd.busy = 1'b1;
		end
		if (cmd.clr_busy) begin
			upd.busy = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (cmd.shift) begin
			rec_q <= prev_rec;
		end else if (is_head) begin
			rec_q <= upd;
		end
	end
endmodule

[rtl/frwt_div.sv]
// Restoring divider, one quotient bit per cycle: 37-bit sum over a small count.
module frwt_div #(
	parameter int unsigned NW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [36+NW-11:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [31:0]   quotient
);
	localparam int unsigned DW = 37 + NW - 11;
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [NW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [NW:0]   trial;
	logic          ge;

	assign trial = {rem_q[NW-1:0], quo_q[DW-1]};
	assign ge = trial >= {1'b0, divisor};
	assign quotient = quo_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one dividend bit, subtract when possible
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, divisor} : trial;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end
endmodule

[rtl/flash_region_wear_table.sv]
// Top level: flash region wear table built as a rotating ring of region cells.
// Every request rotates the ring once before its result is registered; stats requests add a bit-serial
// divide of log2(REGIONS)+32 bits between the rotation and the result.
// Throughput: one request at a time; the next is taken once the result register is free.
// Reset: arst_n clears all counts and marks at once and loads register reset values.
module flash_region_wear_table #(
	parameter int unsigned REGIONS      = 32,
	parameter int unsigned SECTOR_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	frwt_req_if.sink   req,
	frwt_rsp_if.source rsp,
	frwt_cfg_if.sink   cfg
);
	import frwt_pkg::*;

	localparam int unsigned IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int unsigned NW = $clog2(REGIONS + 1);
	localparam int unsigned SW = 32 + NW;
	localparam int unsigned SH = $clog2(SECTOR_BYTES);
	localparam int unsigned DNW = IW + 6;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;

	// Configuration registers
	logic [31:0] base_q, size_q, thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_RESET;
			thr_q  <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BASE:      base_q <= cfg.data;
				CFG_SIZE:      size_q <= cfg.data;
				CFG_THRESHOLD: thr_q  <= cfg.data;
				default: ;
			endcase
		end
	end
	assign cfg.ready = 1'b1;

	// Ring of cells; cell 0 is the head, records move from cell i+1 into cell i
	cell_cmd_t cmd;
	region_t   recs [REGIONS];
	region_t   head;
	assign head = recs[0];

	for (genvar g = 0; g < REGIONS; g++) begin : g_ring
		frwt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.is_head  (g == 0),
			.threshold(thr_q),
			.prev_rec (recs[(g + 1) % REGIONS]),
			.rec      (recs[g])
		);
	end

	// Request decode held for the whole transaction
	state_t       state_q;
	logic [2:0]   req_q;
	logic [31:0]  addr_q;
	logic [2:0]   loc_st_q;
	logic [IW-1:0] loc_idx_q;
	logic [IW:0]  step_q;       // ring position of head record
	logic         hit_q;        // target found or action done
	logic [IW-1:0] best_idx_q;
	logic [31:0]  best_cnt_q;
	logic [31:0]  mn_q, mx_q;
	logic [SW-1:0] sum_q;
	logic [NW-1:0] n_q;
	logic         rsp_valid_q;
	result_t      res_q;

	// Address check at acceptance
	logic [31:0] off;
	logic [2:0]  loc_st;
	logic [31:0] ridx;
	assign off  = req.addr - base_q;
	assign ridx = 32'(off >> SH);
	always_comb begin
		if (req.addr < base_q || off >= size_q) begin
			loc_st = ST_OUTSIDE;
		end else if (ridx >= 32'(REGIONS)) begin
			loc_st = ST_BAD;
		end else begin
			loc_st = ST_OK;
		end
	end

	logic [IW-1:0] pos;
	logic [31:0]   pos_start;
	logic          at_target, hit_now;
	logic [31:0]   crit_lim;
	logic          scan_on;
	assign scan_on   = step_q != (IW + 1)'(REGIONS);
	assign pos       = step_q[IW-1:0];
	assign pos_start = base_q + (32'(pos) << SH);
	assign at_target = (pos == loc_idx_q) && loc_st_q == ST_OK;
	// floor(thr*8/10) = floor(thr*4/5) = (thr * ceil(2^35/10)) >> 32; limit fits in 32 bits
	assign crit_lim  = 32'((64'(thr_q) * 64'd3435973837) >> 32);

	// Head match for current position
	always_comb begin
		hit_now = 1'b0;
		if (state_q == S_SCAN && scan_on) begin
			unique case (req_q)
				REQ_ERASE: begin
					hit_now = at_target;
				end
				REQ_ALLOC: hit_now = !hit_q && !head.busy && !head.worn;
				REQ_FREE:  hit_now = !hit_q && pos_start == addr_q;
				REQ_WORN:  hit_now = at_target;
				default:   hit_now = 1'b0;
			endcase
		end
	end

	// Two-phase scan: even phase updates head, odd phase shifts
	logic phase_q;
	cell_cmd_t cmd_r;
	always_comb begin
		cmd_r = '0;
		if (state_q == S_SCAN && scan_on) begin
			if (phase_q) begin
				cmd_r.shift = 1'b1;
			end else if (hit_now) begin
				unique case (req_q)
					REQ_ERASE: begin
						cmd_r.inc = 1'b1;
						cmd_r.worn_thr = 1'b1;
					end
					REQ_ALLOC: cmd_r.set_busy = 1'b1;
					REQ_FREE:  cmd_r.clr_busy = 1'b1;
					REQ_WORN:  cmd_r.set_worn = 1'b1;
					default: ;
				endcase
			end
		end
	end

	logic div_start, div_done;
	logic [31:0] div_q;
	frwt_div #(.NW(DNW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend((36 + DNW - 11 + 1)'(sum_q)),
		.divisor (DNW'(n_q)),
		.done    (div_done),
		.quotient(div_q)
	);
	assign div_start = state_q == S_SCAN && !scan_on && req_q == REQ_STATS && n_q != '0;

	assign req.ready  = state_q == S_IDLE && !rsp_valid_q;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = res_q.status;
	assign rsp.out_addr = res_q.out_addr;
	assign rsp.erase_count = res_q.erase_count;
	assign rsp.critical = res_q.critical;
	assign rsp.min_count = res_q.min_count;
	assign rsp.max_count = res_q.max_count;
	assign rsp.avg_count = res_q.avg_count;

	logic active;
	assign active = head.cnt != '0 || head.busy;

	always_comb begin
		cmd = cmd_r;
	end

	// Sequencer: state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			res_q       <= '0;
			req_q       <= '0;
			addr_q      <= '0;
			loc_st_q    <= '0;
			loc_idx_q   <= '0;
			best_idx_q  <= '0;
			best_cnt_q  <= '0;
			mn_q        <= '0;
			mx_q        <= '0;
			sum_q       <= '0;
			n_q         <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q     <= req.req_type;
						addr_q    <= req.addr;
						loc_st_q  <= loc_st;
						loc_idx_q <= IW'(ridx);
						step_q    <= '0;
						phase_q   <= 1'b0;
						hit_q     <= 1'b0;
						mn_q      <= '0;
						mx_q      <= '0;
						sum_q     <= '0;
						n_q       <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_on) begin
						phase_q <= !phase_q;
						if (!phase_q) begin
							// observe head record after any update lands next phase
						end else begin
							// head now holds updated record; gather results
							if ((req_q == REQ_ERASE || req_q == REQ_WORN ||
								req_q == REQ_QUERY) && at_target) begin
								res_q.erase_count <= head.cnt;
								res_q.critical <= head.cnt >= crit_lim;
							end
							if (req_q == REQ_ALLOC && !hit_q && head.busy &&
								!head.worn) begin
								// already-allocated region; nothing to do, our own set is handled below
							end
							if (req_q == REQ_BEST && !head.worn &&
								(!hit_q || head.cnt < best_cnt_q)) begin
								hit_q      <= 1'b1;
								best_idx_q <= pos;
								best_cnt_q <= head.cnt;
							end
							if (req_q == REQ_STATS && active) begin
								if (n_q == '0 || head.cnt < mn_q) mn_q <= head.cnt;
								if (head.cnt > mx_q) mx_q <= head.cnt;
								sum_q <= sum_q + SW'(head.cnt);
								n_q   <= n_q + 1'b1;
							end
							step_q <= step_q + 1'b1;
						end
						if (!phase_q && hit_now &&
							(req_q == REQ_ALLOC || req_q == REQ_FREE)) begin
							hit_q      <= 1'b1;
							best_idx_q <= pos;
						end
					end else begin
						state_q <= (req_q == REQ_STATS && n_q != '0) ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q) begin
						unique case (req_q)
							REQ_ERASE, REQ_WORN, REQ_QUERY: begin
								res_q.status    <= loc_st_q;
								res_q.out_addr  <= '0;
								res_q.min_count <= '0;
								res_q.max_count <= '0;
								res_q.avg_count <= '0;
								if (loc_st_q != ST_OK) begin
									res_q.erase_count <= '0;
								end
								if (req_q != REQ_QUERY || loc_st_q != ST_OK) begin
									res_q.critical <= 1'b0;
								end
							end
							REQ_ALLOC: begin
								res_q.erase_count <= '0;
								res_q.critical <= 1'b0;
								res_q.min_count <= '0;
								res_q.max_count <= '0;
								res_q.avg_count <= '0;
								res_q.status <= hit_q ? ST_OK : ST_NONE_FREE;
								res_q.out_addr <= hit_q ?
									base_q + (32'(best_idx_q) << SH) : '0;
							end
							REQ_FREE: begin
								res_q.erase_count <= '0;
								res_q.critical <= 1'b0;
								res_q.out_addr  <= '0;
								res_q.min_count <= '0;
								res_q.max_count <= '0;
								res_q.avg_count <= '0;
								res_q.status <= hit_q ? ST_OK : ST_BAD;
							end
							REQ_BEST: begin
								res_q.critical <= 1'b0;
								res_q.min_count <= '0;
								res_q.max_count <= '0;
								res_q.avg_count <= '0;
								res_q.status <= hit_q ? ST_OK : ST_ALL_WORN;
								res_q.out_addr <= hit_q ?
									base_q + (32'(best_idx_q) << SH) : '0;
								res_q.erase_count <= hit_q ? best_cnt_q : '0;
							end
							REQ_STATS: begin
								res_q.status    <= ST_OK;
								res_q.out_addr  <= '0;
								res_q.erase_count <= '0;
								res_q.critical <= 1'b0;
								res_q.min_count <= mn_q;
								res_q.max_count <= mx_q;
								res_q.avg_count <= (n_q != '0) ? div_q : '0;
							end
							default: begin
								res_q.erase_count <= '0;
								res_q.critical <= 1'b0;
								res_q.out_addr  <= '0;
								res_q.min_count <= '0;
								res_q.max_count <= '0;
								res_q.avg_count <= '0;
								res_q.status <= ST_BAD;
							end
						endcase
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is only presented with the sequencer idle
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> state_q == S_IDLE)
		else $error("result valid while sequencer busy");

	// Ring only rotates during a scan
	a_shift_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> state_q == S_SCAN)
		else $error("ring shift outside scan");

	// Head updates never coincide with a rotation
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> !(cmd.inc || cmd.set_worn || cmd.set_busy || cmd.clr_busy))
		else $error("head update during shift");
endmodule
